[design/tms_pkg.sv]
package tms_pkg;

  // Tape geometry. The head starts on the middle cell.
  localparam int TAPE_CELLS = 1024;
  localparam int TAPE_AW    = $clog2(TAPE_CELLS);

  // Machine alphabet and state space.
  localparam int NUM_SYMBOLS = 16;
  localparam int NUM_STATES  = 16;

  // Field widths of the item and result.
  localparam int OP_W    = 2;
  localparam int STATE_W = 4;
  localparam int SYM_W   = 4;
  localparam int MOVE_W  = 2;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 32;

  // Step counter: a row of nibble cells that pass carries one cell per cycle.
  localparam int CNT_DIGIT_W = 4;
  localparam int CNT_CELLS   = CNT_W / CNT_DIGIT_W;

  // Each tape word carries an epoch tag; a tag that differs from the live
  // epoch marks a blank cell.
  localparam int EPOCH_W = 4;

  // Transition table geometry.
  localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam logic [TAPE_AW-1:0] HEAD_START = TAPE_AW'(TAPE_CELLS / 2);
  localparam logic [TAPE_AW-1:0] TAPE_FIRST = '0;
  localparam logic [TAPE_AW-1:0] TAPE_LAST  = TAPE_AW'(TAPE_CELLS - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [STATE_W-1:0] STATE_START = STATE_W'(1);
  localparam logic [STATE_W-1:0] STATE_HALT  = '0;

  // Item operations.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } tms_op_t;

  // Head moves stored in a transition entry.
  typedef enum logic [MOVE_W-1:0] {
    MV_STAY  = 2'd0,
    MV_RIGHT = 2'd1,
    MV_LEFT  = 2'd2
  } tms_move_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TAPE,
    S_TABLE,
    S_DONE
  } tms_fsm_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [STATE_W-1:0] entry_state;
    logic [SYM_W-1:0]   entry_symbol;
    logic [SYM_W-1:0]   write_symbol;
    logic [MOVE_W-1:0]  move;
    logic [STATE_W-1:0] next_state;
  } tms_in_t;

  typedef struct packed {
    logic [STATE_W-1:0] current_state;
    logic [POS_W-1:0]   head_position;
    logic [SYM_W-1:0]   written_symbol;
    logic               halted;
    logic               off_tape;
    logic [CNT_W-1:0]   step_count;
  } tms_out_t;

  typedef struct packed {
    logic [SYM_W-1:0]   sym;
    logic [MOVE_W-1:0]  mv;
    logic [STATE_W-1:0] nxt;
  } tms_entry_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [SYM_W-1:0]   sym;
  } tms_tape_word_t;

  typedef struct packed {
    logic clear;
    logic inc;
  } tms_cnt_ctrl_t;

  typedef struct packed {
    logic settled;
    logic saturated;
  } tms_cnt_stat_t;

endpackage

[design/turing_machine_stepper.sv]
// Single-tape Turing machine with a 1024-cell tape and a 16 x 16 transition
// table. Load items fill the table, restart items blank the tape and put the
// head on the middle cell in state 1, and step items run one machine step;
// every item returns one status result. Load and unknown items go straight
// from item transfer to result. A step on a running machine passes through
// item transfer, tape read, table read with write-back and result, and also
// waits while a carry ripples through each trailing all-ones nibble of the
// step count, since the count is a row of nibble cells that carry one cell per
// cycle. Any item also waits for as long as a stalled result still holds the
// output register. After reset, and on every 15th restart when the tape epoch
// tag wraps, the tape goes through a clearing pass over all 1024 cells during
// which no item is taken. The input side takes a new item while the previous result still waits in the output register.
module turing_machine_stepper (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tms_pkg::tms_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tms_pkg::tms_out_t out_data
);
  import tms_pkg::*;

  function automatic logic [TBL_AW-1:0] tbl_index(input logic [STATE_W-1:0] st,
                                                  input logic [SYM_W-1:0] sy);
    return TBL_AW'(int'(st) * NUM_SYMBOLS + int'(sy));
  endfunction

  tms_fsm_t fsm_r, fsm_nxt;

  logic [STATE_W-1:0] mstate_r, mstate_nxt;
  logic [TAPE_AW-1:0] head_r, head_nxt;
  logic               stopped_r, stopped_nxt;
  logic               fell_r, fell_nxt;
  logic [SYM_W-1:0]   wrote_r, wrote_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [TAPE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic               sweep_reply_r, sweep_reply_nxt;
  logic               out_valid_r, out_valid_nxt;
  tms_out_t           out_data_r, out_data_nxt;

  logic           in_accept;
  tms_op_t        in_op;
  logic           load_ok;
  logic           step_live;
  logic           clr_done;
  logic           out_free;
  logic           load_out;
  tms_entry_t     entry;
  logic [SYM_W-1:0] tape_sym;

  logic           tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  tms_tape_word_t tape_wdata;
  tms_tape_word_t tape_rdata;
  logic           tbl_we;
  tms_entry_t     tbl_wdata;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [$bits(tms_entry_t)-1:0] tbl_rdata;

  tms_cnt_ctrl_t    cnt_ctrl;
  tms_cnt_stat_t    cnt_stat;
  logic [CNT_W-1:0] cnt_count;

  // Handshake and item decode.
  assign in_accept = in_valid && !in_stall;
  assign in_op     = tms_op_t'(in_data.operation);
  assign out_free  = !out_valid_r || !out_stall;
  assign step_live = !stopped_r && (mstate_r != STATE_HALT);
  assign clr_done  = (clr_addr_r == TAPE_LAST);

  // A load with any field out of range leaves the table alone.
  assign load_ok =
    ({1'b0, in_data.entry_state}  < (STATE_W+1)'(NUM_STATES))  &&
    ({1'b0, in_data.entry_symbol} < (SYM_W+1)'(NUM_SYMBOLS))   &&
    ({1'b0, in_data.write_symbol} < (SYM_W+1)'(NUM_SYMBOLS))   &&
    ({1'b0, in_data.next_state}   < (STATE_W+1)'(NUM_STATES))  &&
    ((in_data.move == MV_STAY) || (in_data.move == MV_RIGHT) ||
     (in_data.move == MV_LEFT));

  // A cell whose tag is not the live epoch has not been written since restart.
  assign tape_sym = (tape_rdata.epoch == epoch_r) ? tape_rdata.sym : '0;
  assign entry    = tms_entry_t'(tbl_rdata);

  // Memory addressing.
  assign tbl_waddr = tbl_index(in_data.entry_state, in_data.entry_symbol);
  assign tbl_wdata = '{sym: in_data.write_symbol, mv: in_data.move,
                       nxt: in_data.next_state};
  assign tbl_raddr = tbl_index(mstate_r, tape_sym);

  tms_ram #(
    .WIDTH ($bits(tms_tape_word_t)),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (head_r),
    .rdata (tape_rdata)
  );

  tms_ram #(
    .WIDTH ($bits(tms_entry_t)),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  tms_step_counter u_counter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cnt_ctrl),
    .stat  (cnt_stat),
    .count (cnt_count)
  );

  // Sequencer next state.
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      S_CLEAR: begin
        if (clr_done) begin
          fsm_nxt = sweep_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_STEP:    fsm_nxt = step_live ? S_TAPE : S_DONE;
            OP_RESTART: fsm_nxt = (epoch_r == EPOCH_LAST) ? S_CLEAR : S_DONE;
            default:    fsm_nxt = S_DONE;
          endcase
        end
      end
      S_TAPE:  fsm_nxt = S_TABLE;
      S_TABLE: fsm_nxt = S_DONE;
      S_DONE: begin
        if (cnt_stat.settled && out_free) begin
          fsm_nxt = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: stall, memory writes, counter control, result load.
  always_comb begin
    in_stall       = 1'b1;
    tape_we        = 1'b0;
    tape_waddr     = clr_addr_r;
    tape_wdata     = '0;
    tbl_we         = 1'b0;
    cnt_ctrl.clear = 1'b0;
    cnt_ctrl.inc   = 1'b0;
    load_out       = 1'b0;
    case (fsm_r)
      S_CLEAR: begin
        tape_we = 1'b1;
      end
      S_IDLE: begin
        in_stall       = 1'b0;
        tbl_we         = in_accept && (in_op == OP_LOAD) && load_ok;
        cnt_ctrl.clear = in_accept && (in_op == OP_RESTART);
      end
      S_TABLE: begin
        tape_we      = 1'b1;
        tape_waddr   = head_r;
        tape_wdata   = '{epoch: epoch_r, sym: entry.sym};
        cnt_ctrl.inc = 1'b1;
      end
      S_DONE: begin
        load_out = cnt_stat.settled && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Machine registers.
  always_comb begin
    mstate_nxt      = mstate_r;
    head_nxt        = head_r;
    stopped_nxt     = stopped_r;
    fell_nxt        = fell_r;
    wrote_nxt       = wrote_r;
    epoch_nxt       = epoch_r;
    clr_addr_nxt    = clr_addr_r;
    sweep_reply_nxt = sweep_reply_r;
    case (fsm_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_done) begin
          sweep_reply_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          wrote_nxt = '0;
          if (in_op == OP_RESTART) begin
            head_nxt    = HEAD_START;
            mstate_nxt  = STATE_START;
            stopped_nxt = 1'b0;
            fell_nxt    = 1'b0;
            // A wrapping epoch tag needs a pass that blanks every cell.
            if (epoch_r == EPOCH_LAST) begin
              epoch_nxt       = EPOCH_FIRST;
              sweep_reply_nxt = 1'b1;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      S_TABLE: begin
        wrote_nxt  = entry.sym;
        mstate_nxt = entry.nxt;
        // Moving past either end keeps the head and stops the machine.
        case (tms_move_t'(entry.mv))
          MV_RIGHT: begin
            if (head_r == TAPE_LAST) begin
              fell_nxt    = 1'b1;
              stopped_nxt = 1'b1;
            end else begin
              head_nxt = head_r + 1'b1;
            end
          end
          MV_LEFT: begin
            if (head_r == TAPE_FIRST) begin
              fell_nxt    = 1'b1;
              stopped_nxt = 1'b1;
            end else begin
              head_nxt = head_r - 1'b1;
            end
          end
          default: begin
            head_nxt = head_r;
          end
        endcase
        if (entry.nxt == STATE_HALT) begin
          stopped_nxt = 1'b1;
        end
      end
      default: begin
        mstate_nxt = mstate_r;
      end
    endcase
  end

  // Result register, loaded once the step count has settled.
  always_comb begin
    out_data_nxt = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{current_state:  mstate_r,
                        head_position:  POS_W'(head_r),
                        written_symbol: wrote_r,
                        halted:         stopped_r || (mstate_r == STATE_HALT),
                        off_tape:       fell_r,
                        step_count:     cnt_count};
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= S_CLEAR;
      mstate_r      <= STATE_START;
      head_r        <= HEAD_START;
      stopped_r     <= 1'b0;
      fell_r        <= 1'b0;
      wrote_r       <= '0;
      epoch_r       <= EPOCH_FIRST;
      clr_addr_r    <= '0;
      sweep_reply_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      fsm_r         <= fsm_nxt;
      mstate_r      <= mstate_nxt;
      head_r        <= head_nxt;
      stopped_r     <= stopped_nxt;
      fell_r        <= fell_nxt;
      wrote_r       <= wrote_nxt;
      epoch_r       <= epoch_nxt;
      clr_addr_r    <= clr_addr_nxt;
      sweep_reply_r <= sweep_reply_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // The step count has finished rippling whenever a new item may enter.
  a_idle_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_IDLE) |-> cnt_stat.settled)
    else $error("step counter still carrying while idle");

  // Only a running machine reaches the tape read.
  a_tape_live: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_TAPE) |-> (!stopped_r && (mstate_r != STATE_HALT)))
    else $error("step started on a stopped machine");

  // Leaving the tape always stops the machine.
  a_fell_stops: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fell_r) |-> stopped_r)
    else $error("off-tape flag set without halting");

  // The step count changes only when an item is in progress.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((fsm_r == S_IDLE) && !in_accept) |=> $stable(cnt_count))
    else $error("step count changed while idle");
`endif

endmodule

[design/tms_ram.sv]
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/tms_count_cell.sv]
module tms_count_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic                            carry_in,
  output logic [tms_pkg::CNT_DIGIT_W-1:0] digit,
  output logic                            carry_out
);
  import tms_pkg::*;

  logic [CNT_DIGIT_W-1:0] digit_r;
  logic [CNT_DIGIT_W-1:0] digit_nxt;
  logic                   carry_r;
  logic                   carry_nxt;

  // Add an incoming carry; a digit that wraps hands a carry on next cycle.
  always_comb begin
    digit_nxt = digit_r;
    carry_nxt = 1'b0;
    if (clear) begin
      digit_nxt = '0;
    end else if (carry_in) begin
      digit_nxt = digit_r + 1'b1;
      carry_nxt = &digit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
      carry_r <= 1'b0;
    end else begin
      digit_r <= digit_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign digit     = digit_r;
  assign carry_out = carry_r;

endmodule

[design/tms_step_counter.sv]
module tms_step_counter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tms_pkg::tms_cnt_ctrl_t    ctrl,
  output tms_pkg::tms_cnt_stat_t    stat,
  output logic [tms_pkg::CNT_W-1:0] count
);
  import tms_pkg::*;

  logic [CNT_CELLS:0] carry;

  // A saturated count takes no further increments.
  assign carry[0] = ctrl.inc && !stat.saturated;

  // Row of digit cells, each passing its carry to the next one up.
  for (genvar gi = 0; gi < CNT_CELLS; gi++) begin : g_cell
    tms_count_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (ctrl.clear),
      .carry_in  (carry[gi]),
      .digit     (count[gi*CNT_DIGIT_W +: CNT_DIGIT_W]),
      .carry_out (carry[gi+1])
    );
  end

  // The count is exact once no carry is still travelling along the row.
  assign stat.settled   = ~|carry[CNT_CELLS:1];
  assign stat.saturated = (&count) && stat.settled;

endmodule

[dv/tms_status_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the stepper, predicts one status per accepted
// item transfer and compares it with the status transfers in order.
module tms_status_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tms_pkg::tms_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tms_pkg::tms_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import tms_pkg::*;

  localparam int SHOW_LIMIT = 10;

  // Shadow copy of the machine.
  logic [SYM_W-1:0]   tape_sym  [TAPE_CELLS];
  logic               cell_used [TAPE_CELLS];
  tms_entry_t         rules     [TBL_DEPTH];
  logic [POS_W-1:0]   head;
  logic [STATE_W-1:0] state;
  logic [CNT_W-1:0]   steps;
  logic               stopped;
  logic               fell_off;

  // Statuses still owed by the block, oldest first.
  tms_out_t status_due[$];
  tms_out_t predicted;
  tms_out_t oldest;
  logic     bad;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Blank the tape and put the machine back at its start.
  task automatic restart_machine();
    foreach (cell_used[i]) cell_used[i] = 1'b0;
    head     = HEAD_START;
    state    = STATE_START;
    steps    = '0;
    stopped  = 1'b0;
    fell_off = 1'b0;
  endtask

  // Apply one item to the shadow machine and return the status it reports.
  task automatic advance_machine(input tms_in_t item, output tms_out_t status);
    logic [POS_W-1:0] pos;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] wrote;
    tms_entry_t       rule;
    wrote = '0;
    case (item.operation)
      OP_LOAD: begin
        // A load with the unused move code is dropped.
        if (item.move == MV_STAY || item.move == MV_RIGHT || item.move == MV_LEFT) begin
          rule.sym = item.write_symbol;
          rule.mv  = item.move;
          rule.nxt = item.next_state;
          rules[{item.entry_state, item.entry_symbol}] = rule;
        end
      end
      OP_STEP: begin
        if (!stopped && state != STATE_HALT) begin
          pos  = head;
          sym  = cell_used[pos] ? tape_sym[pos] : '0;
          rule = rules[{state, sym}];
          tape_sym[pos]  = rule.sym;
          cell_used[pos] = 1'b1;
          wrote          = rule.sym;
          // Moving past either end leaves the head in place and halts.
          if (rule.mv == MV_RIGHT) begin
            if (pos == TAPE_LAST) begin
              fell_off = 1'b1;
              stopped  = 1'b1;
            end else begin
              pos = pos + 1'b1;
            end
          end else if (rule.mv == MV_LEFT) begin
            if (pos == TAPE_FIRST) begin
              fell_off = 1'b1;
              stopped  = 1'b1;
            end else begin
              pos = pos - 1'b1;
            end
          end
          head  = pos;
          state = rule.nxt;
          if (state == STATE_HALT) stopped = 1'b1;
          if (steps != '1) steps = steps + 1'b1;
        end
      end
      OP_RESTART: restart_machine();
      default: ;
    endcase
    status.current_state  = state;
    status.head_position  = head;
    status.written_symbol = wrote;
    status.halted         = stopped || state == STATE_HALT;
    status.off_tape       = fell_off;
    status.step_count     = steps;
  endtask

  // Retire status transfers against the oldest prediction, then predict for
  // a new item transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_machine();
      status_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("%0t: status with none expected: state %0d head %0d wrote %0d",
                     $realtime, out_data.current_state, out_data.head_position,
                     out_data.written_symbol);
        end else begin
          oldest = status_due.pop_front();
          bad = (out_data.current_state  !== oldest.current_state)  ||
                (out_data.head_position  !== oldest.head_position)  ||
                (out_data.written_symbol !== oldest.written_symbol) ||
                (out_data.halted         !== oldest.halted)         ||
                (out_data.off_tape       !== oldest.off_tape)       ||
                (out_data.step_count     !== oldest.step_count);
          if (bad) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT) begin
              $display("%0t: status mismatch", $realtime);
              $display("  expected state %0d head %0d wrote %0d halted %b off %b steps %0d",
                       oldest.current_state, oldest.head_position, oldest.written_symbol,
                       oldest.halted, oldest.off_tape, oldest.step_count);
              $display("  actual   state %0d head %0d wrote %0d halted %b off %b steps %0d",
                       out_data.current_state, out_data.head_position,
                       out_data.written_symbol, out_data.halted, out_data.off_tape,
                       out_data.step_count);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_machine(in_data, predicted);
        status_due.push_back(predicted);
      end
    end
    pending = status_due.size();
  end

endmodule

[dv/tb_turing_machine_stepper.sv]
`timescale 1ns / 100ps

module tb_turing_machine_stepper;
  import tms_pkg::*;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 64;
  localparam int RUNAWAY_STEPS  = 520;
  localparam int RUN_RIGHT_PROG = 2;
  localparam int RUN_LEFT_PROG  = 12;
  localparam int HOLD_PROG      = 5;

  // Codes the block must tolerate but never defines.
  localparam logic [OP_W-1:0]   OP_ILLEGAL = 2'd3;
  localparam logic [MOVE_W-1:0] MV_ILLEGAL = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  tms_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tms_out_t out_data;

  int fail_count;
  int pending;
  int sent_items     = 0;
  int send_idle_pct  = 9;
  int recv_stall_pct = 83;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // States and symbols of the program being run; every pair is loaded.
  logic [STATE_W-1:0] prog_states[$];
  logic [SYM_W-1:0]   prog_syms[$];

  turing_machine_stepper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tms_status_checker status_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, or one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tms_in_t make_item(logic [OP_W-1:0] op, logic [STATE_W-1:0] es,
                                        logic [SYM_W-1:0] ey, logic [SYM_W-1:0] ws,
                                        logic [MOVE_W-1:0] mv, logic [STATE_W-1:0] ns);
    tms_in_t item;
    item.operation    = op;
    item.entry_state  = es;
    item.entry_symbol = ey;
    item.write_symbol = ws;
    item.move         = mv;
    item.next_state   = ns;
    return item;
  endfunction

  // An item of the given operation with every other field random.
  function automatic tms_in_t random_item(logic [OP_W-1:0] op);
    return make_item(op, STATE_W'($urandom_range(15)), SYM_W'($urandom_range(15)),
                     SYM_W'($urandom_range(15)), MOVE_W'($urandom_range(3)),
                     STATE_W'($urandom_range(15)));
  endfunction

  // A random transition for (es, ey) that stays inside the program.
  function automatic tms_in_t rule_for(logic [STATE_W-1:0] es, logic [SYM_W-1:0] ey,
                                       logic runaway, logic [MOVE_W-1:0] run_mv);
    logic [SYM_W-1:0]   ws;
    logic [MOVE_W-1:0]  mv;
    logic [STATE_W-1:0] ns;
    ws = prog_syms[$urandom_range(prog_syms.size() - 1)];
    mv = runaway ? run_mv : MOVE_W'($urandom_range(2));
    if (!runaway && $urandom_range(7) == 0) ns = STATE_HALT;
    else ns = prog_states[$urandom_range(prog_states.size() - 1)];
    return make_item(OP_LOAD, es, ey, ws, mv, ns);
  endfunction

  // Offer one item and hold it until the transfer; counted items move the
  // idle profile along.
  task automatic send_item(input tms_in_t item, input bit counts);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (counts) begin
      sent_items++;
      if (sent_items < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 9;
        recv_stall_pct = 83;
      end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 83;
        recv_stall_pct = 9;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    end
  endtask

  // Items the block must ignore or that touch only unused table rows.
  task automatic send_noise();
    tms_in_t item;
    item = random_item(OP_ILLEGAL);
    case ($urandom_range(2))
      1: begin
        item.operation = OP_LOAD;
        item.move      = MV_ILLEGAL;
      end
      2: begin
        item.operation   = OP_LOAD;
        item.entry_state = STATE_HALT;
        item.move        = MOVE_W'($urandom_range(2));
      end
      default: ;
    endcase
    send_item(item, 1'b0);
  endtask

  // Stop offering and wait until every status has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int                     prog_no;
    int                     n_steps;
    int                     pick;
    logic                   runaway;
    logic [MOVE_W-1:0]      run_mv;
    logic [NUM_STATES-1:0]  st_mask;
    logic [NUM_SYMBOLS-1:0] sy_mask;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: unknown operation, dropped and unused loads, a short
    // program that halts, steps while halted, and restarts.
    send_item(make_item(OP_ILLEGAL, '1, '1, '1, MV_ILLEGAL, '1), 1'b0);
    send_item(make_item(OP_LOAD, 4'd1, 4'd0, 4'd15, MV_ILLEGAL, 4'd15), 1'b0);
    send_item(make_item(OP_LOAD, STATE_HALT, 4'd15, 4'd15, MV_LEFT, 4'd15), 1'b0);
    send_item(make_item(OP_LOAD, 4'd1, 4'd0, 4'd15, MV_RIGHT, 4'd15), 1'b0);
    send_item(make_item(OP_LOAD, 4'd15, 4'd0, 4'd0, MV_LEFT, 4'd2), 1'b0);
    send_item(make_item(OP_LOAD, 4'd2, 4'd15, 4'd8, MV_STAY, 4'd3), 1'b0);
    send_item(make_item(OP_LOAD, 4'd3, 4'd8, 4'd1, MV_LEFT, STATE_HALT), 1'b0);
    repeat (6) send_item(make_item(OP_STEP, '0, '0, '0, MV_STAY, '0), 1'b0);
    send_item(make_item(OP_RESTART, '0, '0, '0, MV_STAY, '0), 1'b0);
    repeat (3) send_item(make_item(OP_STEP, '1, '1, '1, MV_ILLEGAL, '1), 1'b0);
    send_item(make_item(OP_RESTART, '1, '1, '1, MV_ILLEGAL, '1), 1'b0);
    send_item(make_item(OP_ILLEGAL, '0, '0, '0, MV_STAY, '0), 1'b0);

    // Random programs: load every (state, symbol) pair the program can
    // reach, restart, then step with reloads, restarts and noise mixed in.
    for (prog_no = 0; sent_items < RANDOM_ITEMS; prog_no++) begin
      runaway = (prog_no == RUN_RIGHT_PROG || prog_no == RUN_LEFT_PROG);
      run_mv  = (prog_no == RUN_RIGHT_PROG) ? MV_RIGHT : MV_LEFT;
      st_mask = NUM_STATES'(1) << STATE_START;
      sy_mask = NUM_SYMBOLS'(1);
      repeat ($urandom_range(3))
        st_mask[STATE_W'($urandom_range(1, NUM_STATES - 1))] = 1'b1;
      repeat ($urandom_range(3))
        sy_mask[SYM_W'($urandom_range(0, NUM_SYMBOLS - 1))] = 1'b1;
      prog_states.delete();
      prog_syms.delete();
      for (int i = 1; i < NUM_STATES; i++)
        if (st_mask[i]) prog_states.push_back(STATE_W'(i));
      for (int i = 0; i < NUM_SYMBOLS; i++)
        if (sy_mask[i]) prog_syms.push_back(SYM_W'(i));

      foreach (prog_states[s]) begin
        foreach (prog_syms[y]) begin
          if ($urandom_range(9) == 0) send_noise();
          send_item(rule_for(prog_states[s], prog_syms[y], runaway, run_mv), 1'b1);
        end
      end

      // Now and then the sender waits for the block to go empty.
      if (prog_no % 7 == 3) drain_results();
      send_item(random_item(OP_RESTART), 1'b1);

      // Long receiver hold-off while items keep coming.
      if (prog_no == HOLD_PROG) hold_reqs++;

      n_steps = runaway ? RUNAWAY_STEPS : $urandom_range(1, 40);
      repeat (n_steps) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_noise();
        end else if (!runaway && pick < 14) begin
          send_item(rule_for(prog_states[$urandom_range(prog_states.size() - 1)],
                             prog_syms[$urandom_range(prog_syms.size() - 1)],
                             1'b0, MV_STAY), 1'b1);
        end else if (!runaway && pick < 16) begin
          send_item(random_item(OP_RESTART), 1'b1);
        end
        send_item(random_item(OP_STEP), 1'b1);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
